// File: rtl/itf_pkg.sv
`timescale 1ns / 1ps
// itf_pkg: shared types, sizes and character codes for the integer to text formatter.
// Used by itf_cell and integer_to_text_formatter_unit. No dependencies.
package itf_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_OUTPUT = 64;
    localparam int PREC_CAP   = 40;
    localparam int NCELLS     = 22;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int NDIG_W     = $clog2(NCELLS + 1);
    localparam int REM_W      = $clog2(MAX_OUTPUT + 1);

    localparam logic [2:0] CONV_SDEC  = 3'd0;
    localparam logic [2:0] CONV_UDEC  = 3'd1;
    localparam logic [2:0] CONV_HEXL  = 3'd2;
    localparam logic [2:0] CONV_HEXU  = 3'd3;
    localparam logic [2:0] CONV_OCT   = 3'd4;
    localparam logic [2:0] CONV_PTR   = 3'd5;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LX     = 8'h78;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } t_radix;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DOUBLE,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_radix   radix;
    } t_cell_ctrl;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base_ch;
        base_ch = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
        end else begin
            digit_char = base_ch + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// File: rtl/integer_to_text_formatter_unit.sv
`timescale 1ns / 1ps
// integer_to_text_formatter_unit: printf-style integer conversion, one character per transaction.
// Depends on itf_pkg and itf_cell.
//
// One input transaction at a time. The value is shifted, one bit per cycle, into a row of
// 22 digit cells. The row then drops leading zero digits (up to 21) until the leading digit
// is on top. A setup state computes the padding counts, and the text follows at one
// character per cycle while the output is not stalled (at most 63 characters). The next
// input transaction can be taken in the cycle after the last character is loaded into
// the output register.
module integer_to_text_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_value,
    input  logic [2:0]  i_conversion,
    input  logic        i_long_arg,
    input  logic        i_left_align,
    input  logic        i_plus_sign,
    input  logic        i_space_sign,
    input  logic        i_alt_form,
    input  logic        i_zero_fill,
    input  logic [5:0]  i_field_width,
    input  logic        i_has_min_digits,
    input  logic [5:0]  i_min_digits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_char_out,
    output logic        o_last_char
);
    import itf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_SETUP,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        EM_LPAD,
        EM_SIGN,
        EM_PRE0,
        EM_PREX,
        EM_ZPAD,
        EM_DIGIT,
        EM_RPAD
    } t_emit_sel;

    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [VALUE_BITS-1:0] r_val;
    t_radix               r_radix;
    logic                 r_upper;
    logic                 r_left;
    logic                 r_zfill;
    logic                 r_hasp;
    logic [5:0]           r_prec;
    logic [5:0]           r_width;
    logic                 r_pre_sign;
    logic [7:0]           r_sign_ch;
    logic                 r_pre0;
    logic                 r_prex;
    logic [NDIG_W-1:0]    r_ndig;
    logic [5:0]           r_lpad;
    logic [5:0]           r_zpad;
    logic [5:0]           r_rpad;
    logic [REM_W-1:0]     r_remain;
    logic                 r_out_valid;
    logic [7:0]           r_char;
    logic                 r_last;

    // input decode
    logic                  w_accept;
    logic                  w_signed;
    logic [VALUE_BITS-1:0] w_wide;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_nonzero;
    logic                  w_alt;
    logic                  w_hex;
    logic                  w_oct;
    logic                  w_sign_any;

    // setup arithmetic
    logic [5:0]            w_prec_fill;
    logic [1:0]            w_plen;
    logic [6:0]            w_body;
    logic                  w_wide_field;
    logic [5:0]            w_wpad;
    logic [6:0]            w_total;

    // emission
    logic                  w_emit_go;
    t_emit_sel             w_sel;
    logic [7:0]            n_char;

    // cell row
    t_cell_ctrl            w_ctrl;
    logic [NCELLS-1:0]     w_cin;
    logic [NCELLS-1:0]     w_cout;
    logic [3:0]            w_low   [NCELLS];
    logic [3:0]            w_digit [NCELLS];
    logic [3:0]            w_top;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        w_signed = (i_conversion == CONV_SDEC);
        w_hex    = (i_conversion == CONV_HEXL) || (i_conversion == CONV_HEXU)
                || (i_conversion == CONV_PTR);
        w_oct    = (i_conversion == CONV_OCT);
        w_alt    = i_alt_form || (i_conversion == CONV_PTR);
        if (i_long_arg) begin
            w_wide = i_value[VALUE_BITS-1:0];
        end else if (w_signed) begin
            w_wide = {{(VALUE_BITS-32){i_value[31]}}, i_value[31:0]};
        end else begin
            w_wide = {{(VALUE_BITS-32){1'b0}}, i_value[31:0]};
        end
        w_neg      = w_signed && w_wide[VALUE_BITS-1];
        w_mag      = w_neg ? (~w_wide + 1'b1) : w_wide;
        w_nonzero  = (w_wide != '0);
        w_sign_any = w_neg || (w_signed && (i_plus_sign || i_space_sign));
    end

    always_comb begin
        if (r_hasp && (r_prec > {{(6-NDIG_W){1'b0}}, r_ndig})) begin
            w_prec_fill = r_prec - {{(6-NDIG_W){1'b0}}, r_ndig};
        end else begin
            w_prec_fill = 6'd0;
        end
        w_plen       = {1'b0, r_pre_sign} + {1'b0, r_pre0} + {1'b0, r_prex};
        w_body       = {5'd0, w_plen} + {1'b0, w_prec_fill} + {{(7-NDIG_W){1'b0}}, r_ndig};
        w_wide_field = ({1'b0, r_width} > w_body);
        w_wpad       = w_wide_field ? (r_width - w_body[5:0]) : 6'd0;
        w_total      = w_wide_field ? {1'b0, r_width} : w_body;
    end

    assign w_emit_go = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        priority if (r_lpad != 6'd0) begin
            w_sel = EM_LPAD;
        end else if (r_pre_sign) begin
            w_sel = EM_SIGN;
        end else if (r_pre0) begin
            w_sel = EM_PRE0;
        end else if (r_prex) begin
            w_sel = EM_PREX;
        end else if (r_zpad != 6'd0) begin
            w_sel = EM_ZPAD;
        end else if (r_ndig != '0) begin
            w_sel = EM_DIGIT;
        end else begin
            w_sel = EM_RPAD;
        end
    end

    always_comb begin
        unique case (w_sel)
            EM_SIGN:  n_char = r_sign_ch;
            EM_PRE0:  n_char = CH_ZERO;
            EM_PREX:  n_char = r_upper ? CH_UX : CH_LX;
            EM_ZPAD:  n_char = CH_ZERO;
            EM_DIGIT: n_char = digit_char(w_top, r_upper);
            default:  n_char = CH_SPACE;
        endcase
    end

    // cell row control
    assign w_top = w_digit[NCELLS-1];

    always_comb begin
        w_ctrl.radix = r_radix;
        w_ctrl.op    = CELL_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctrl.op = CELL_CLEAR;
                end
            end
            S_CONV: w_ctrl.op = CELL_DOUBLE;
            S_NORM: begin
                if ((w_top == 4'd0) && (r_ndig > 1)) begin
                    w_ctrl.op = CELL_SHIFT;
                end
            end
            S_EMIT: begin
                if (w_emit_go && (w_sel == EM_DIGIT)) begin
                    w_ctrl.op = CELL_SHIFT;
                end
            end
            default: w_ctrl.op = CELL_HOLD;
        endcase
    end

    assign w_cin[0] = r_val[VALUE_BITS-1];
    assign w_low[0] = 4'd0;

    genvar g;
    generate
        for (g = 0; g < NCELLS; g++) begin : g_cell
            if (g > 0) begin : g_link
                assign w_cin[g] = w_cout[g-1];
                assign w_low[g] = w_digit[g-1];
            end
            itf_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_carry (w_cin[g]),
                .i_digit (w_low[g]),
                .o_carry (w_cout[g]),
                .o_digit (w_digit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ndig      <= '0;
            r_lpad      <= '0;
            r_zpad      <= '0;
            r_rpad      <= '0;
            r_remain    <= '0;
            r_pre_sign  <= 1'b0;
            r_pre0      <= 1'b0;
            r_prex      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_emit_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state    <= S_CONV;
                        r_cnt      <= '0;
                        r_val      <= w_mag;
                        r_radix    <= w_hex ? RADIX_HEX : (w_oct ? RADIX_OCT : RADIX_DEC);
                        r_upper    <= (i_conversion == CONV_HEXU);
                        r_left     <= i_left_align;
                        r_zfill    <= i_zero_fill && !i_left_align && !i_has_min_digits;
                        r_hasp     <= i_has_min_digits;
                        r_prec     <= (i_min_digits > 6'(PREC_CAP)) ? 6'(PREC_CAP)
                                                                    : i_min_digits;
                        r_width    <= i_field_width;
                        r_pre_sign <= w_sign_any;
                        r_sign_ch  <= w_neg ? CH_MINUS : (i_plus_sign ? CH_PLUS : CH_SPACE);
                        r_pre0     <= w_alt && w_nonzero && (w_hex || w_oct);
                        r_prex     <= w_alt && w_nonzero && w_hex;
                        r_ndig     <= NDIG_W'(NCELLS);
                    end
                end
                S_CONV: begin
                    r_val <= {r_val[VALUE_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if ((w_top == 4'd0) && (r_ndig > 1)) begin
                        r_ndig <= r_ndig - 1'b1;
                    end else begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_lpad   <= (r_left || r_zfill) ? 6'd0 : w_wpad;
                    r_zpad   <= (r_zfill ? w_wpad : 6'd0) + w_prec_fill;
                    r_rpad   <= r_left ? w_wpad : 6'd0;
                    r_remain <= REM_W'(w_total);
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit_go) begin
                        r_out_valid <= 1'b1;
                        r_char      <= n_char;
                        r_last      <= (r_remain == REM_W'(1));
                        r_remain    <= r_remain - 1'b1;
                        if (r_remain == REM_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                        unique case (w_sel)
                            EM_LPAD:  r_lpad     <= r_lpad - 1'b1;
                            EM_SIGN:  r_pre_sign <= 1'b0;
                            EM_PRE0:  r_pre0     <= 1'b0;
                            EM_PREX:  r_prex     <= 1'b0;
                            EM_ZPAD:  r_zpad     <= r_zpad - 1'b1;
                            EM_DIGIT: r_ndig     <= r_ndig - 1'b1;
                            default:  r_rpad     <= r_rpad - 1'b1;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_char;
    assign o_last_char = r_last;

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV) && (r_cnt == '0))
        else $error("conversion did not start after input transaction");

    a_row_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> !w_cout[NCELLS-1])
        else $error("digit row overflowed");

    a_norm_keeps_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_ndig != '0))
        else $error("digit count fell to zero");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_go && (r_remain == REM_W'(1))) |=> (r_state == S_IDLE) && o_last_char)
        else $error("last character did not end the item");

    a_no_empty_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_remain != '0))
        else $error("emitting with nothing left");

endmodule

// File: rtl/itf_cell.sv
`timescale 1ns / 1ps
// itf_cell: one digit cell of the conversion row (base 8, 10 or 16).
// Doubles its digit with the carry from below, takes the digit below, clears or holds. Uses itf_pkg.
module itf_cell (
    input  logic               i_clk,
    input  itf_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_carry,
    input  logic [3:0]         i_digit,
    output logic               o_carry,
    output logic [3:0]         o_digit
);
    import itf_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_half;
    logic [4:0] w_base;
    logic [4:0] w_dbl;

    always_comb begin
        unique case (i_ctrl.radix)
            RADIX_OCT: begin
                w_half = 4'd4;
                w_base = 5'd8;
            end
            RADIX_HEX: begin
                w_half = 4'd8;
                w_base = 5'd16;
            end
            default: begin
                w_half = 4'd5;
                w_base = 5'd10;
            end
        endcase
    end

    // carry out depends on the held digit and the radix only, so the row does not ripple
    assign o_carry = (r_digit >= w_half);
    assign w_dbl   = {r_digit, i_carry} - (o_carry ? w_base : 5'd0);
    assign o_digit = r_digit;

    always_comb begin
        unique case (i_ctrl.op)
            CELL_CLEAR:  n_digit = 4'd0;
            CELL_DOUBLE: n_digit = w_dbl[3:0];
            CELL_SHIFT:  n_digit = i_digit;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
